@@ src/fatrd_pkg.sv @@
// ----------------------------------------------------------------------------
// fatrd_pkg: shared types and constants of the root directory entry decoder
// Entry layout offsets, special byte codes, and the structs that link the
// byte collector to the name and metadata emitter.
// ----------------------------------------------------------------------------
package fatrd_pkg;

	localparam int unsigned ENTRY_LEN  = 32;
	localparam int unsigned POS_W      = $clog2(ENTRY_LEN);
	localparam int unsigned ADDR_W     = POS_W + 1;  // two entry banks
	localparam int unsigned IDX_W      = 4;           // name byte index 0..10

	localparam logic [POS_W-1:0] POS_FIRST   = POS_W'(0);
	localparam logic [POS_W-1:0] POS_ATTR    = POS_W'(11);
	localparam logic [POS_W-1:0] POS_DATE_LO = POS_W'(16);
	localparam logic [POS_W-1:0] POS_DATE_HI = POS_W'(17);
	localparam logic [POS_W-1:0] POS_CLUS_LO = POS_W'(26);
	localparam logic [POS_W-1:0] POS_CLUS_HI = POS_W'(27);
	localparam logic [POS_W-1:0] POS_SIZE_0  = POS_W'(28);
	localparam logic [POS_W-1:0] POS_SIZE_1  = POS_W'(29);
	localparam logic [POS_W-1:0] POS_SIZE_2  = POS_W'(30);
	localparam logic [POS_W-1:0] POS_LAST    = POS_W'(ENTRY_LEN - 1);

	localparam logic [IDX_W-1:0] IDX_BASE_LAST = IDX_W'(7);
	localparam logic [IDX_W-1:0] IDX_EXT_FIRST = IDX_W'(8);
	localparam logic [IDX_W-1:0] IDX_EXT_LAST  = IDX_W'(10);

	localparam logic [7:0]  FREE_CODE   = 8'h00;
	localparam logic [7:0]  SPACE_CODE  = 8'h20;
	localparam logic [7:0]  ERASED_CODE = 8'hE5;
	localparam logic [7:0]  LFN_ATTR    = 8'h0F;
	localparam logic [7:0]  DIR_ATTR    = 8'h10;
	localparam logic [7:0]  DOT_CODE    = 8'h2E;
	localparam logic [11:0] YEAR_BASE   = 12'd1980;
	localparam logic [15:0] DAY_MASK    = 16'b0000_0000_0001_1111;

	typedef struct packed {
		logic [7:0]  attributes;
		logic [15:0] date;
		logic [31:0] file_size;
		logic [15:0] first_cluster;
	} meta_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_req_t;

	typedef struct packed {
		logic  valid;
		logic  bank;
		meta_t meta;
	} start_t;

	typedef enum logic [1:0] {
		E_IDLE,
		E_READ,
		E_EVAL,
		E_META
	} emit_state_t;

endpackage

@@ src/fatrd_emit.sv @@
// ----------------------------------------------------------------------------
// fatrd_emit: entry store and result emitter
// Holds two entry banks in a synchronous RAM, reads back the 8.3 name bytes
// of a finished entry and drives the result register.
// ----------------------------------------------------------------------------
module fatrd_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  fatrd_pkg::wr_req_t wr,
	input  fatrd_pkg::start_t  start,
	output logic               busy,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         name_char,
	output logic               entry_done,
	output logic [7:0]         attributes,
	output logic               is_directory,
	output logic [4:0]         day,
	output logic [3:0]         month,
	output logic [11:0]        year,
	output logic [31:0]        file_size,
	output logic [15:0]        first_cluster
);
	import fatrd_pkg::*;

	logic [7:0] mem [2*ENTRY_LEN];
	logic [7:0] rdata_q;

	emit_state_t      state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             dot_q, dot_d;
	logic             bank_q;
	meta_t            meta_q;

	logic       can_load, load, ld_meta, rd_en;
	logic [7:0] ld_char;

	logic        valid_q, done_q, dir_q;
	logic [7:0]  char_q, attr_q;
	logic [4:0]  day_q;
	logic [3:0]  month_q;
	logic [11:0] year_q;
	logic [31:0] size_q;
	logic [15:0] clus_q;

	assign can_load = !valid_q || out_ready;
	assign busy     = (state_q != E_IDLE);

	// entry RAM: collector writes one bank, emitter reads the other
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rdata_q <= mem[{bank_q, POS_W'(idx_q)}];
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		dot_d   = dot_q;
		load    = 1'b0;
		ld_meta = 1'b0;
		ld_char = rdata_q;
		rd_en   = 1'b0;
		unique case (state_q)
			E_IDLE: begin
				if (start.valid) begin
					idx_d   = '0;
					dot_d   = 1'b0;
					state_d = E_READ;
				end
			end
			E_READ: begin
				rd_en   = 1'b1;
				state_d = E_EVAL;
			end
			E_EVAL: begin
				if (can_load) begin
					if (idx_q <= IDX_BASE_LAST) begin
						load    = (rdata_q != SPACE_CODE);
						idx_d   = idx_q + 1'b1;
						state_d = E_READ;
					end else if (idx_q == IDX_EXT_FIRST && rdata_q == SPACE_CODE) begin
						state_d = E_META;
					end else if (idx_q == IDX_EXT_FIRST && !dot_q) begin
						load    = 1'b1;
						ld_char = DOT_CODE;
						dot_d   = 1'b1;
					end else begin
						load = 1'b1;
						if (idx_q == IDX_EXT_LAST) begin
							state_d = E_META;
						end else begin
							idx_d   = idx_q + 1'b1;
							state_d = E_READ;
						end
					end
				end
			end
			E_META: begin
				if (can_load) begin
					load    = 1'b1;
					ld_meta = 1'b1;
					state_d = E_IDLE;
				end
			end
			default: state_d = E_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			idx_q   <= '0;
			dot_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			dot_q   <= dot_d;
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == E_IDLE && start.valid) begin
			bank_q <= start.bank;
			meta_q <= start.meta;
		end
		if (load) begin
			if (ld_meta) begin
				char_q  <= '0;
				done_q  <= 1'b1;
				attr_q  <= meta_q.attributes;
				dir_q   <= (meta_q.attributes == DIR_ATTR);
				day_q   <= 5'(meta_q.date & DAY_MASK);
				month_q <= meta_q.date[8:5];
				year_q  <= 12'(meta_q.date[15:9]) + YEAR_BASE;
				size_q  <= meta_q.file_size;
				clus_q  <= meta_q.first_cluster;
			end else begin
				char_q  <= ld_char;
				done_q  <= 1'b0;
				attr_q  <= '0;
				dir_q   <= 1'b0;
				day_q   <= '0;
				month_q <= '0;
				year_q  <= '0;
				size_q  <= '0;
				clus_q  <= '0;
			end
		end
	end

	assign out_valid     = valid_q;
	assign name_char     = char_q;
	assign entry_done    = done_q;
	assign attributes    = attr_q;
	assign is_directory  = dir_q;
	assign day           = day_q;
	assign month         = month_q;
	assign year          = year_q;
	assign file_size     = size_q;
	assign first_cluster = clus_q;

`ifndef NO_ASSERTIONS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start.valid |-> state_q == E_IDLE)
		else $error("entry started while emitter busy");

	a_read_then_eval: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == E_READ |=> state_q == E_EVAL)
		else $error("RAM read not followed by evaluation");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != E_IDLE |-> idx_q <= IDX_EXT_LAST)
		else $error("name index beyond extension");

	a_meta_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == E_META && can_load) |=> (valid_q && done_q && state_q == E_IDLE))
		else $error("metadata result not issued on leaving META");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && wr.en) |-> wr.addr[ADDR_W-1] != bank_q)
		else $error("write into bank under readout");
`endif

endmodule

@@ src/fat_root_entry_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// fat_root_entry_decoder_unit: FAT12 root directory entry decoder
// Collects 32-byte directory entries and emits 8.3 name characters followed
// by one metadata result per live entry.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/data_byte) takes the raw root directory
//   region one byte per transfer, entries back to back. Output channel
//   (out_valid/out_ready/...) gives one transfer per name character, then one
//   transfer with entry_done set carrying attributes, date, size and cluster.
//   Free, erased and long-name entries give no output at all.
// Timing:
//   Bytes are taken one per cycle while in_ready is high. Entries are stored
//   in a two-bank RAM, so the next entry is collected while the previous one
//   is read out. Readout takes a RAM read and an evaluation per name byte,
//   plus one evaluation for the dot; the first result is registered through
//   the READ and EVAL states after an entry's last byte when byte 0 is not a
//   space; without an output stall the metadata result is loaded before the
//   next entry's last byte, so the sustained rate is one byte per cycle.
// Stall:
//   When the receiver holds out_ready low, the result register holds; the
//   input keeps flowing until the last byte of the following entry, where
//   in_ready drops until the readout of the earlier entry has finished.
// Reset:
//   arst_n clears the byte position, bank select and emitter; no output.
// ----------------------------------------------------------------------------
module fat_root_entry_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  name_char,
	output logic        entry_done,
	output logic [7:0]  attributes,
	output logic        is_directory,
	output logic [4:0]  day,
	output logic [3:0]  month,
	output logic [11:0] year,
	output logic [31:0] file_size,
	output logic [15:0] first_cluster
);
	import fatrd_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic             wbank_q;
	logic [7:0]       first_q;
	meta_t            meta_q;
	logic             emit_busy;
	logic             in_xfer;
	logic             last_byte;
	logic             keep;
	wr_req_t          wr;
	start_t           start;

	// hold the last byte of an entry until the other bank is free again
	assign last_byte = (pos_q == POS_LAST);
	assign in_ready  = !(last_byte && emit_busy);
	assign in_xfer   = in_valid && in_ready;

	// drop free, erased and long-name entries
	assign keep = (first_q != FREE_CODE) && (first_q != ERASED_CODE) &&
	              (meta_q.attributes != LFN_ATTR);

	assign wr.en   = in_xfer;
	assign wr.addr = {wbank_q, pos_q};
	assign wr.data = data_byte;

	// metadata is complete once the incoming top size byte is merged in
	assign start.valid                = in_xfer && last_byte && keep;
	assign start.bank                 = wbank_q;
	assign start.meta.attributes      = meta_q.attributes;
	assign start.meta.date            = meta_q.date;
	assign start.meta.first_cluster   = meta_q.first_cluster;
	assign start.meta.file_size       = {data_byte, meta_q.file_size[23:0]};

	// advance the byte position and flip banks at each entry boundary
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			wbank_q <= 1'b0;
		end else if (in_xfer) begin
			pos_q <= pos_q + 1'b1;
			if (last_byte) begin
				wbank_q <= !wbank_q;
			end
		end
	end

	// capture the bytes that decide dropping and form the metadata result
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			unique case (pos_q)
				POS_FIRST:   first_q                       <= data_byte;
				POS_ATTR:    meta_q.attributes             <= data_byte;
				POS_DATE_LO: meta_q.date[7:0]              <= data_byte;
				POS_DATE_HI: meta_q.date[15:8]             <= data_byte;
				POS_CLUS_LO: meta_q.first_cluster[7:0]     <= data_byte;
				POS_CLUS_HI: meta_q.first_cluster[15:8]    <= data_byte;
				POS_SIZE_0:  meta_q.file_size[7:0]         <= data_byte;
				POS_SIZE_1:  meta_q.file_size[15:8]        <= data_byte;
				POS_SIZE_2:  meta_q.file_size[23:16]       <= data_byte;
				default:     meta_q.file_size[31:24]       <= meta_q.file_size[31:24];
			endcase
		end
	end

	fatrd_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr            (wr),
		.start         (start),
		.busy          (emit_busy),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.name_char     (name_char),
		.entry_done    (entry_done),
		.attributes    (attributes),
		.is_directory  (is_directory),
		.day           (day),
		.month         (month),
		.year          (year),
		.file_size     (file_size),
		.first_cluster (first_cluster)
	);

endmodule
